/* src/mtsw_pkg.sv */
`timescale 1ns / 1ps

package mtsw_pkg;

    // Panel command bytes of the window header.
    localparam logic [7:0] CMD_COLUMN = 8'h2a;
    localparam logic [7:0] CMD_ROW    = 8'h2b;
    localparam logic [7:0] CMD_WRITE  = 8'h2c;

    // Register reset values.
    localparam logic [7:0] RESET_ROW_OFFSET   = 8'd115;
    localparam logic [7:0] RESET_COLUMN_START = 8'h19;
    localparam logic [7:0] RESET_COLUMN_END   = 8'h3a;

    // Register indexes on the configuration port.
    localparam int REG_INDEX_WIDTH = 2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROW_OFFSET   = 2'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COLUMN_START = 2'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COLUMN_END   = 2'd2;
    localparam int CFG_ADDR_WIDTH = 4;

    localparam int QUEUE_DEPTH = 2;

    // Sequencer steps: seven header bytes, then six pixel bytes.
    localparam int PIX_BYTES  = 6;
    localparam int STEP_WIDTH = 4;
    localparam logic [STEP_WIDTH-1:0] STEP_COLUMN_CMD  = 4'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_COLUMN_LO   = 4'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_COLUMN_HI   = 4'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_ROW_CMD     = 4'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_ROW_LO      = 4'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_ROW_HI      = 4'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_WRITE_CMD   = 4'd6;
    localparam logic [STEP_WIDTH-1:0] STEP_PIXEL_FIRST = 4'd7;
    localparam logic [STEP_WIDTH-1:0] STEP_LAST        = 4'd12;

    typedef struct packed {
        logic [7:0] row_offset;
        logic [7:0] column_start;
        logic [7:0] column_end;
    } cfg_t;

    // One classified block as it travels from the front to the back.
    typedef struct packed {
        logic [PIX_BYTES-1:0][7:0] pixels;
        logic [7:0]                row;
        logic                      first;
        logic                      begins;
        logic                      ends;
    } desc_t;

    // Upper-row nibble onto the even bits, lower-row nibble onto the odd bits.
    function automatic logic [7:0] interleave(input logic [3:0] top_nib,
                                              input logic [3:0] bottom_nib);
        logic [7:0] r;
        for (int i = 0; i < 4; i++)
        begin
            r[2*i]     = top_nib[i];
            r[2*i + 1] = bottom_nib[i];
        end
        return r;
    endfunction

endpackage

/* src/mtsw_ifs.sv */
`timescale 1ns / 1ps

interface mtsw_block_if;
    logic        valid;
    logic        ready;
    logic [23:0] top_bytes;
    logic [23:0] bottom_bytes;
    logic [5:0]  tile_row;
    logic [1:0]  pair_index;
    logic        first_block;
    logic        last_block;

    modport source (output valid, top_bytes, bottom_bytes, tile_row, pair_index,
                    first_block, last_block, input ready);
    modport sink (input valid, top_bytes, bottom_bytes, tile_row, pair_index,
                  first_block, last_block, output ready);
endinterface

interface mtsw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_command;
    logic       is_pixel;
    logic       begins_tile;
    logic       ends_tile;
    logic       last;

    modport source (output valid, out_byte, is_command, is_pixel, begins_tile,
                    ends_tile, last, input ready);
    modport sink (input valid, out_byte, is_command, is_pixel, begins_tile,
                  ends_tile, last, output ready);
endinterface

/* src/mtsw_front.sv */
`timescale 1ns / 1ps

// Accepts blocks, interleaves the pixel bytes and works out the panel row.
module mtsw_front
(
    input  logic               clk,
    input  logic               rst_n,
    mtsw_block_if.sink         blocks,
    input  logic [7:0]         row_offset,
    output logic               push_valid,
    input  logic               push_ready,
    output mtsw_pkg::desc_t    push_desc
);

    logic            valid_reg;
    logic            valid_next;
    mtsw_pkg::desc_t desc_reg;
    mtsw_pkg::desc_t desc_next;
    logic            accept;

    assign blocks.ready = !valid_reg || push_ready;
    assign accept       = blocks.valid && blocks.ready;
    assign push_valid   = valid_reg;
    assign push_desc    = desc_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        desc_next = desc_reg;
        if (accept)
        begin
            for (int k = 0; k < mtsw_pkg::PIX_BYTES; k++)
            begin
                desc_next.pixels[k] = mtsw_pkg::interleave(
                    blocks.top_bytes[(20 - 4*k) +: 4],
                    blocks.bottom_bytes[(20 - 4*k) +: 4]);
            end
            desc_next.row    = {blocks.tile_row, 2'b00} + row_offset
                               + {6'd0, blocks.pair_index};
            desc_next.first  = blocks.first_block;
            desc_next.begins = blocks.first_block && (blocks.pair_index == 2'd0);
            desc_next.ends   = blocks.last_block && (blocks.pair_index == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

/* src/mtsw_queue.sv */
`timescale 1ns / 1ps

// Short queue of classified blocks between the front and the back.
module mtsw_queue
#(
    parameter int Depth = mtsw_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  mtsw_pkg::desc_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output mtsw_pkg::desc_t rd_data
);

    localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountWidth = $clog2(Depth + 1);

    mtsw_pkg::desc_t         mem [Depth];
    logic [PtrWidth-1:0]     wr_ptr_reg;
    logic [PtrWidth-1:0]     wr_ptr_next;
    logic [PtrWidth-1:0]     rd_ptr_reg;
    logic [PtrWidth-1:0]     rd_ptr_next;
    logic [CountWidth-1:0]   count_reg;
    logic [CountWidth-1:0]   count_next;
    logic                    wr_en;
    logic                    rd_en;

    assign wr_ready = (count_reg != CountWidth'(Depth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_ready && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // The occupancy can never pass the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(Depth))
        else $error("queue occupancy beyond depth");

    // When the queue is empty, the read and write pointers are equal.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

/* src/mtsw_back.sv */
`timescale 1ns / 1ps

// Steps through the header and pixel bytes of one block, one byte a cycle unless the receiver stalls.
module mtsw_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  mtsw_pkg::cfg_t  cfg,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mtsw_pkg::desc_t pop_desc,
    mtsw_byte_if.source     stream
);

    logic                             cur_valid_reg;
    logic                             cur_valid_next;
    mtsw_pkg::desc_t                  cur_reg;
    mtsw_pkg::desc_t                  cur_next;
    logic [mtsw_pkg::STEP_WIDTH-1:0]  step_reg;
    logic [mtsw_pkg::STEP_WIDTH-1:0]  step_next;
    logic [mtsw_pkg::STEP_WIDTH-1:0]  pix_off;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [7:0]                       byte_reg;
    logic                             cmd_reg;
    logic                             pix_reg;
    logic                             begins_reg;
    logic                             ends_reg;
    logic                             last_reg;
    logic [7:0]                       sel_byte;
    logic                             sel_cmd;
    logic                             sel_pix;
    logic                             emit;
    logic                             finish;
    logic                             load;

    assign emit      = cur_valid_reg && (!out_valid_reg || stream.ready);
    assign finish    = emit && (step_reg == mtsw_pkg::STEP_LAST);
    assign load      = pop_valid && (!cur_valid_reg || finish);
    assign pop_ready = load;
    assign pix_off   = step_reg - mtsw_pkg::STEP_PIXEL_FIRST;

    always_comb
    begin
        sel_byte = 8'd0;
        sel_cmd  = 1'b0;
        sel_pix  = 1'b0;
        unique case (step_reg) inside
            mtsw_pkg::STEP_COLUMN_CMD:
            begin
                sel_byte = mtsw_pkg::CMD_COLUMN;
                sel_cmd  = 1'b1;
            end
            mtsw_pkg::STEP_COLUMN_LO: sel_byte = cfg.column_start;
            mtsw_pkg::STEP_COLUMN_HI: sel_byte = cfg.column_end;
            mtsw_pkg::STEP_ROW_CMD:
            begin
                sel_byte = mtsw_pkg::CMD_ROW;
                sel_cmd  = 1'b1;
            end
            mtsw_pkg::STEP_ROW_LO, mtsw_pkg::STEP_ROW_HI: sel_byte = cur_reg.row;
            mtsw_pkg::STEP_WRITE_CMD:
            begin
                sel_byte = mtsw_pkg::CMD_WRITE;
                sel_cmd  = 1'b1;
            end
            [mtsw_pkg::STEP_PIXEL_FIRST:mtsw_pkg::STEP_LAST]:
            begin
                sel_byte = cur_reg.pixels[pix_off[2:0]];
                sel_pix  = 1'b1;
            end
            default:
            begin
                sel_byte = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_next       = pop_desc;
            step_next      = pop_desc.first ? mtsw_pkg::STEP_COLUMN_CMD
                                            : mtsw_pkg::STEP_PIXEL_FIRST;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= mtsw_pkg::STEP_COLUMN_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            byte_reg   <= sel_byte;
            cmd_reg    <= sel_cmd;
            pix_reg    <= sel_pix;
            begins_reg <= cur_reg.begins && (step_reg == mtsw_pkg::STEP_COLUMN_CMD);
            ends_reg   <= cur_reg.ends && (step_reg == mtsw_pkg::STEP_LAST);
            last_reg   <= (step_reg == mtsw_pkg::STEP_LAST);
        end
    end

    assign stream.valid       = out_valid_reg;
    assign stream.out_byte    = byte_reg;
    assign stream.is_command  = cmd_reg;
    assign stream.is_pixel    = pix_reg;
    assign stream.begins_tile = begins_reg;
    assign stream.ends_tile   = ends_reg;
    assign stream.last        = last_reg;

    // The sequencer never walks past the final pixel byte.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (step_reg <= mtsw_pkg::STEP_LAST))
        else $error("sequencer step out of range");

    // A block without a header starts straight at the pixel bytes.
    a_skip_header: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !pop_desc.first) |=> (step_reg == mtsw_pkg::STEP_PIXEL_FIRST))
        else $error("headerless block did not start at pixel data");

    // The tile start can only fall on the column command.
    a_begins_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && begins_reg) |-> (cmd_reg && byte_reg == mtsw_pkg::CMD_COLUMN))
        else $error("tile start not on column command");

    // The tile end can only fall on the last byte of a block.
    a_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ends_reg) |-> (last_reg && pix_reg))
        else $error("tile end not on last pixel byte");

endmodule

/* src/mono_tft_tile_stream_writer_top.sv */
`timescale 1ns / 1ps

// Mono TFT tile stream writer.
//
// Blocks of pixel data arrive on the "blocks" channel: three bytes of an upper
// row and three of the lower row of a row pair, with the tile row, the pair
// index and first/last flags. A valid/ready transfer accepts one block. Each
// block leaves on the "stream" channel as six interleaved pixel bytes, preceded
// by a seven-byte window header (column, row and write commands with their
// arguments) when the block opens a row pair; the final byte carries "last".
// The stream moves one byte per transfer, so a header block occupies the
// output for thirteen transfers and any other block for six; the byte sequencer
// in the back end steps through them. With everything empty the first byte is
// registered in turn by the front stage, the queue, the back end and its output.
// A front stage and a two-entry queue decouple the sides: blocks keep being
// accepted while the sequencer drains earlier ones or the receiver stalls,
// until the queue fills. A stalled output byte simply holds its register.
// Reset empties the pipeline and loads the row offset, column start and column
// end registers with their defaults; they are written over the APB port, which
// is only to be used while the block is idle.
module mono_tft_tile_stream_writer_top
#(
    parameter int QueueDepth = mtsw_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    mtsw_block_if.sink                          blocks,
    mtsw_byte_if.source                         stream,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mtsw_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    mtsw_pkg::cfg_t  cfg_reg;
    mtsw_pkg::cfg_t  cfg_next;
    logic            cfg_write;
    logic [mtsw_pkg::REG_INDEX_WIDTH-1:0] reg_index;

    logic            q_wr_valid;
    logic            q_wr_ready;
    mtsw_pkg::desc_t q_wr_data;
    logic            q_rd_valid;
    logic            q_rd_ready;
    mtsw_pkg::desc_t q_rd_data;

    // Register file: word addressed, the low address bits are ignored.
    assign pready    = 1'b1;
    assign reg_index = paddr[mtsw_pkg::CFG_ADDR_WIDTH-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                mtsw_pkg::REG_ROW_OFFSET:   cfg_next.row_offset   = pwdata[7:0];
                mtsw_pkg::REG_COLUMN_START: cfg_next.column_start = pwdata[7:0];
                mtsw_pkg::REG_COLUMN_END:   cfg_next.column_end   = pwdata[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mtsw_pkg::REG_ROW_OFFSET:   prdata = {24'd0, cfg_reg.row_offset};
            mtsw_pkg::REG_COLUMN_START: prdata = {24'd0, cfg_reg.column_start};
            mtsw_pkg::REG_COLUMN_END:   prdata = {24'd0, cfg_reg.column_end};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_offset   <= mtsw_pkg::RESET_ROW_OFFSET;
            cfg_reg.column_start <= mtsw_pkg::RESET_COLUMN_START;
            cfg_reg.column_end   <= mtsw_pkg::RESET_COLUMN_END;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front classifies each block and prepares its pixel bytes.
    mtsw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .blocks     (blocks),
        .row_offset (cfg_reg.row_offset),
        .push_valid (q_wr_valid),
        .push_ready (q_wr_ready),
        .push_desc  (q_wr_data)
    );

    mtsw_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // The back walks through the bytes of each block into the output register.
    mtsw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_rd_valid),
        .pop_ready (q_rd_ready),
        .pop_desc  (q_rd_data),
        .stream    (stream)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Testbench for the mono TFT tile stream writer.
//
// Blocks of pixel data go in on the block channel and the panel byte stream
// comes out of the byte channel. For every block accepted, the bench works
// out the bytes the panel should see from its own copy of the three window
// registers. That means an optional seven-byte window header, six interleaved
// pixel bytes, and the tile start, tile end and last markers. It queues them
// in order. Every byte transfer on the output is compared with the oldest
// queued byte, field by field.
//
// The run has four parts. First a short directed set under the reset register
// values. Then directed blocks under extreme register values, including a
// write to an unused register address. Then random traffic made mostly of
// well-formed tiles, with some unstructured blocks mixed in, over several
// register settings. Finally a long receiver hold-off while the sender keeps
// offering blocks, so that the internal queue fills and the input stalls.
module testbench;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 11;
    // Settling wait after the last owed byte; allow a good margin.
    localparam int SETTLE_CYCLES   = 16;
    // Longest legitimate quiet stretch is the receiver hold-off below.
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_PHASES   = 4;
    localparam int BLOCKS_PER_PHASE = 16;

    // Address 12 decodes to no register, so a write there must change nothing.
    localparam logic [mtsw_pkg::REG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [23:0] top_bytes;
        logic [23:0] bottom_bytes;
        logic [5:0]  tile_row;
        logic [1:0]  pair_index;
        logic        first_block;
        logic        last_block;
    } block_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       is_pixel;
        logic       begins_tile;
        logic       ends_tile;
        logic       last;
    } panel_byte_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [mtsw_pkg::CFG_ADDR_WIDTH-1:0] paddr;
    logic [31:0]                         pwdata;
    logic [31:0]                         prdata;
    logic                                pready;

    mtsw_block_if blocks_if ();
    mtsw_byte_if  stream_if ();

    mono_tft_tile_stream_writer_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .blocks  (blocks_if),
        .stream  (stream_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the window registers, updated on every write we issue.
    mtsw_pkg::cfg_t panel_cfg;
    // Panel bytes still owed by the block, oldest first.
    panel_byte_t expected_bytes[$];

    int mismatches    = 0;
    int bytes_checked = 0;
    int blocks_sent   = 0;
    int header_blocks = 0;
    int tile_ends     = 0;
    int reg_writes    = 0;

    // Sender burst state, and a switch to turn its gaps off entirely.
    int burst_left    = 0;
    bit sender_gaps   = 1'b1;
    // A non-zero value asks the receiver to hold off for that many cycles.
    int hold_request  = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Work out the panel bytes for one accepted block and queue them.
    // A block that opens a row pair is preceded by the window header.
    // Pixel bytes take one nibble of each row at a time, from the top,
    // with the upper row on the even bits and the lower row on the odd bits.
    function automatic void predict_panel_bytes(input block_t b);
        panel_byte_t seq[13];
        logic [7:0]  row;
        logic [3:0]  top_nib;
        logic [3:0]  bottom_nib;
        logic [7:0]  pix;
        int          n;
        n = 0;
        // Eight-bit sum, so the panel row wraps past 255 by itself.
        row = {b.tile_row, 2'b00} + panel_cfg.row_offset + {6'd0, b.pair_index};
        if (b.first_block)
        begin
            seq[0] = '{mtsw_pkg::CMD_COLUMN,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[1] = '{panel_cfg.column_start, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[2] = '{panel_cfg.column_end,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[3] = '{mtsw_pkg::CMD_ROW,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[4] = '{row,                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[5] = '{row,                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            seq[6] = '{mtsw_pkg::CMD_WRITE,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            n = 7;
        end
        for (int k = 0; k < mtsw_pkg::PIX_BYTES; k++)
        begin
            top_nib    = b.top_bytes[23 - 4*k -: 4];
            bottom_nib = b.bottom_bytes[23 - 4*k -: 4];
            for (int i = 0; i < 4; i++)
            begin
                pix[2*i]     = top_nib[i];
                pix[2*i + 1] = bottom_nib[i];
            end
            seq[n] = '{pix, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
            n++;
        end
        // Chip select opens on the first header of pair zero and releases
        // after the closing block of pair three.
        seq[0].begins_tile = b.first_block && (b.pair_index == 2'd0);
        seq[n-1].ends_tile = b.last_block && (b.pair_index == 2'd3);
        seq[n-1].last      = 1'b1;
        for (int i = 0; i < n; i++)
            expected_bytes.push_back(seq[i]);
    endfunction

    function automatic void note_mismatch(input string what, input panel_byte_t want,
                                          input panel_byte_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t ns, %s: expected byte %02h cmd %b pix %b %s",
                     $time, what, want.out_byte, want.is_command, want.is_pixel,
                     $sformatf("begins %b ends %b last %b", want.begins_tile,
                               want.ends_tile, want.last));
            $display("    got byte %02h cmd %b pix %b begins %b ends %b last %b",
                     got.out_byte, got.is_command, got.is_pixel, got.begins_tile,
                     got.ends_tile, got.last);
        end
    endfunction

    function automatic block_t make_block(input logic [23:0] top, input logic [23:0] bottom,
                                          input logic [5:0] trow, input logic [1:0] pair,
                                          input logic first, input logic closing);
        make_block = '{top, bottom, trow, pair, first, closing};
    endfunction

    function automatic block_t random_block();
        block_t b;
        b.top_bytes    = 24'($urandom());
        b.bottom_bytes = 24'($urandom());
        b.tile_row     = 6'($urandom_range(0, 63));
        b.pair_index   = 2'($urandom_range(0, 3));
        b.first_block  = 1'($urandom_range(0, 1));
        b.last_block   = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Offer one block and wait for its transfer. The sender works in bursts;
    // between bursts it may drop valid for a random gap. It is always called
    // at a rising edge and returns at the edge of the transfer, so the next
    // call can change the payload before the following edge.
    task automatic send_block(input block_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (sender_gaps && gap > 0)
            begin
                blocks_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        blocks_if.valid        <= 1'b1;
        blocks_if.top_bytes    <= b.top_bytes;
        blocks_if.bottom_bytes <= b.bottom_bytes;
        blocks_if.tile_row     <= b.tile_row;
        blocks_if.pair_index   <= b.pair_index;
        blocks_if.first_block  <= b.first_block;
        blocks_if.last_block   <= b.last_block;
        do
            @(posedge clk);
        while (!(blocks_if.valid === 1'b1 && blocks_if.ready === 1'b1));
        blocks_sent++;
        if (b.first_block)
            header_blocks++;
        if (b.last_block && b.pair_index == 2'd3)
            tile_ends++;
        predict_panel_bytes(b);
    endtask

    // Stop offering, let every owed byte arrive, then wait out the settling
    // time so that the block is truly idle before a register write.
    task automatic drain_stream();
        blocks_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup cycle, then an access cycle that completes at the
    // edge where pready is high. A spare idle wait follows so that back-to-back
    // writes never raise and lower psel in the same step.
    task automatic write_register(input logic [mtsw_pkg::REG_INDEX_WIDTH-1:0] index,
                                  input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            mtsw_pkg::REG_ROW_OFFSET:   panel_cfg.row_offset   = value;
            mtsw_pkg::REG_COLUMN_START: panel_cfg.column_start = value;
            mtsw_pkg::REG_COLUMN_END:   panel_cfg.column_end   = value;
            default:                    ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [7:0] row_offset, input logic [7:0] column_start,
                              input logic [7:0] column_end);
        drain_stream();
        write_register(mtsw_pkg::REG_ROW_OFFSET, row_offset);
        write_register(mtsw_pkg::REG_COLUMN_START, column_start);
        write_register(mtsw_pkg::REG_COLUMN_END, column_end);
    endtask

    // A well-formed tile: four row pairs on one tile row, each pair of one to
    // three blocks with the first and last flags where they belong.
    task automatic send_random_tile();
        block_t     b;
        int         pair_blocks;
        logic [5:0] trow;
        trow = 6'($urandom_range(0, 63));
        for (int p = 0; p < 4; p++)
        begin
            pair_blocks = $urandom_range(1, 3);
            for (int j = 0; j < pair_blocks; j++)
            begin
                b = random_block();
                b.tile_row    = trow;
                b.pair_index  = 2'(p);
                b.first_block = (j == 0);
                b.last_block  = (j == pair_blocks - 1);
                send_block(b);
            end
        end
    endtask

    // Reset register values: opening and closing a tile, single-block pairs,
    // pixel extremes, and a panel row that wraps past 255.
    task automatic test_reset_window();
        send_block(make_block(24'hffffff, 24'h000000, 6'd0,  2'd0, 1'b1, 1'b0));
        send_block(make_block(24'h000000, 24'hffffff, 6'd0,  2'd0, 1'b0, 1'b1));
        send_block(make_block(24'ha5a5a5, 24'h5a5a5a, 6'd1,  2'd1, 1'b1, 1'b1));
        send_block(make_block(24'h123456, 24'h89abcd, 6'd31, 2'd2, 1'b1, 1'b0));
        send_block(make_block(24'hf0f0f0, 24'h0f0f0f, 6'd31, 2'd3, 1'b0, 1'b1));
        send_block(make_block(24'hffffff, 24'hffffff, 6'd63, 2'd3, 1'b1, 1'b1));
        send_block(make_block(24'h000000, 24'h000000, 6'd63, 2'd0, 1'b0, 1'b0));
        send_block(make_block(24'hc3c3c3, 24'h3c3c3c, 6'd0,  2'd3, 1'b0, 1'b0));
        send_block(make_block(24'h800001, 24'h000080, 6'd5,  2'd0, 1'b0, 1'b1));
    endtask

    // Register extremes, then a write to an unused address, which must leave
    // the window header exactly as it was.
    task automatic test_window_extremes();
        set_window(8'd0, 8'd0, 8'd0);
        send_block(make_block(24'h0f0f0f, 24'hf0f0f0, 6'd0,  2'd0, 1'b1, 1'b0));
        send_block(make_block(24'h555555, 24'haaaaaa, 6'd0,  2'd0, 1'b0, 1'b1));
        send_block(make_block(24'h13579b, 24'h2468ac, 6'd63, 2'd3, 1'b1, 1'b1));
        set_window(8'd255, 8'd255, 8'd255);
        send_block(make_block(24'hfedcba, 24'h012345, 6'd63, 2'd3, 1'b1, 1'b0));
        send_block(make_block(24'h7e7e7e, 24'h818181, 6'd0,  2'd1, 1'b1, 1'b1));
        send_block(make_block(24'hffff00, 24'h00ffff, 6'd10, 2'd3, 1'b0, 1'b1));
        drain_stream();
        write_register(REG_UNUSED, 8'h5a);
        send_block(make_block(24'h3c3c3c, 24'hc3c3c3, 6'd20, 2'd0, 1'b1, 1'b0));
        send_block(make_block(24'haaaaaa, 24'h555555, 6'd20, 2'd2, 1'b1, 1'b1));
    endtask

    // Random traffic over several register settings. Most of it is whole
    // tiles; about one choice in five is an unstructured block.
    task automatic test_random_tiles();
        int phase_start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       set_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                1:       set_window(8'd255, 8'd0, 8'd255);
                2:       set_window(mtsw_pkg::RESET_ROW_OFFSET,
                                    mtsw_pkg::RESET_COLUMN_START,
                                    mtsw_pkg::RESET_COLUMN_END);
                default: set_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            phase_start = blocks_sent;
            while (blocks_sent - phase_start < BLOCKS_PER_PHASE)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_block(random_block());
                else
                    send_random_tile();
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers
    // header blocks back to back; the queue fills and the input must stall
    // without losing or repeating anything.
    task automatic test_output_hold_off();
        block_t b;
        drain_stream();
        sender_gaps  = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < 12; i++)
        begin
            b = random_block();
            b.first_block = 1'b1;
            send_block(b);
        end
        sender_gaps = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        rst_n                  <= 1'b0;
        blocks_if.valid        <= 1'b0;
        blocks_if.top_bytes    <= '0;
        blocks_if.bottom_bytes <= '0;
        blocks_if.tile_row     <= '0;
        blocks_if.pair_index   <= '0;
        blocks_if.first_block  <= 1'b0;
        blocks_if.last_block   <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        panel_cfg = '{mtsw_pkg::RESET_ROW_OFFSET, mtsw_pkg::RESET_COLUMN_START,
                      mtsw_pkg::RESET_COLUMN_END};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_extremes();
        test_random_tiles();
        test_output_hold_off();

        // Everything owed must arrive; the watchdog catches a hang here.
        drain_stream();

        $display("Covered %0d blocks (%0d with a window header, %0d closing a tile),",
                 blocks_sent, header_blocks, tile_ends);
        $display("%0d bytes checked, %0d register writes, random stalls on both sides %s",
                 bytes_checked, reg_writes, "and one long receiver hold-off.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: checks every byte transfer and drives ready. It switches
    // between stretches of always ready, random stalls and a fixed one-in-three
    // stall, and honours a hold-off request by counting the cycles itself.
    initial
    begin
        panel_byte_t got;
        panel_byte_t want;
        int          stall_mode;
        int          stretch_left;
        int          hold_left;
        int          beat;
        logic        next_ready;
        stall_mode   = 0;
        stretch_left = 0;
        hold_left    = 0;
        beat         = 0;
        stream_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stream_if.valid === 1'b1 && stream_if.ready === 1'b1)
            begin
                got = '{stream_if.out_byte, stream_if.is_command, stream_if.is_pixel,
                        stream_if.begins_tile, stream_if.ends_tile, stream_if.last};
                if (expected_bytes.size() == 0)
                    note_mismatch("byte with nothing expected", '0, got);
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (got !== want)
                        note_mismatch("wrong byte", want, got);
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_mode   = $urandom_range(0, 2);
                    stretch_left = $urandom_range(20, 80);
                end
                stretch_left--;
                case (stall_mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = ($urandom_range(0, 3) != 0);
                    default: next_ready = (beat % 3 != 0);
                endcase
            end
            stream_if.ready <= next_ready;
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for
    // too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((blocks_if.valid === 1'b1 && blocks_if.ready === 1'b1) ||
                (stream_if.valid === 1'b1 && stream_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timed out after %0d cycles with no transfer, %0d bytes still owed.",
                 IDLE_LIMIT, expected_bytes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
